// ===== hw/rtl/sitda_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the signed
// integer to decimal ASCII converter. No dependencies.

package sitda_pkg;

   // default width of the signed input value
   localparam int VALUE_BITS_DEFAULT = 32;

   // character codes
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture magnitude and sign of a new value
      logic step;   // resolve the current digit position
   } sitda_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       neg;        // value is negative, needs a leading '-'
      logic       emit;       // current digit is significant
      logic       last;       // current digit is the units digit
      logic [7:0] char_code;  // ASCII of the current digit
   } sitda_status_type;

   // d * 10^k, evaluated at elaboration only
   function automatic logic [63:0] pow10_times(input int k, input int d);
      logic [63:0] acc;
      acc = 64'(d);
      for (int i = 0; i < k; i++) begin
         acc = acc * 64'd10;
      end
      return acc;
   endfunction

   // decimal digits needed for the largest magnitude 2^(bits-1)
   function automatic int num_digits(input int bits);
      logic [63:0] top;
      logic [63:0] pw;
      int          n;
      top = 64'd1 << (bits - 1);
      pw  = 64'd10;
      n   = 1;
      for (int i = 1; i < 20; i++) begin
         if (top >= pw) begin
            n = i + 1;
         end
         pw = pw * 64'd10;
      end
      return n;
   endfunction

endpackage

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Instantiates sitda_ctrl and sitda_datapath; depends on sitda_pkg.
//
// Takes one signed two's-complement value per req beat and returns its
// decimal text on rsp, one ASCII character per beat, most significant
// first: a leading '-' for negative values, no leading zeros, a single '0'
// for zero, with rsp_tlast on the final character. The most negative value
// prints in full. Each value passes through the accept state, the sign state and
// then a digit step for each of the digit positions for VALUE_BITS (10 at 32 bits),
// leading-zero positions included, since the extractor resolves one decimal
// position per cycle, while the output is not stalled, against a table of
// multiples of powers of ten. The next value is taken once the units digit has
// entered the output register.

module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]   req_tdata,  // [VALUE_BITS-1:0] value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // [7:0] char_code
   output logic                              rsp_tlast   // is_last
);
   import sitda_pkg::*;

   sitda_cmd_type    cmd;
   sitda_status_type status;

   sitda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   sitda_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .value  (req_tdata[VALUE_BITS-1:0]),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// ===== hw/rtl/sitda_datapath.sv =====
// Datapath: magnitude register and an extractor that resolves one digit per
// cycle while stepped, most significant digit first. Depends on sitda_pkg.

module sitda_datapath #(
   parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [VALUE_BITS-1:0]       value,
   input  sitda_pkg::sitda_cmd_type    cmd,
   output sitda_pkg::sitda_status_type status
);
   import sitda_pkg::*;

   localparam int NDIG  = num_digits(VALUE_BITS);
   localparam int POS_W = (NDIG > 1) ? $clog2(NDIG) : 1;
   // 9 * 10^(NDIG-1) stays below 2^(VALUE_BITS+3)
   localparam int TBL_W = VALUE_BITS + 3;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  seen_ff, seen_in;
   logic                  neg_ff, neg_in;

   // multiples 1..9 of each power of ten
   logic [TBL_W-1:0] mult_tbl [NDIG][9];

   for (genvar k = 0; k < NDIG; k++) begin : g_pow
      for (genvar d = 1; d <= 9; d++) begin : g_mul
         localparam logic [63:0] MULT = pow10_times(k, d);
         assign mult_tbl[k][d-1] = TBL_W'(MULT);
      end
   end

   logic [TBL_W-1:0]      mag_ext;
   logic [3:0]            digit;
   logic [TBL_W-1:0]      sub_val;
   logic                  pos_zero;

   assign mag_ext  = TBL_W'(mag_ff);
   assign pos_zero = (pos_ff == '0);

   // digit = largest multiple of 10^pos that still fits
   always_comb begin
      digit   = 4'd0;
      sub_val = '0;
      for (int j = 0; j < 9; j++) begin
         if (mag_ext >= mult_tbl[pos_ff][j]) begin
            digit   = 4'(j + 1);
            sub_val = mult_tbl[pos_ff][j];
         end
      end
   end

   // next-state for load and step
   always_comb begin
      mag_in  = mag_ff;
      pos_in  = pos_ff;
      seen_in = seen_ff;
      neg_in  = neg_ff;
      if (cmd.load) begin
         neg_in  = value[VALUE_BITS-1];
         mag_in  = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
         pos_in  = POS_W'(NDIG - 1);
         seen_in = 1'b0;
      end else if (cmd.step) begin
         mag_in  = mag_ff - VALUE_BITS'(sub_val);
         seen_in = seen_ff | (digit != 4'd0);
         if (!pos_zero) begin
            pos_in = pos_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         neg_ff  <= 1'b0;
         pos_ff  <= '0;
      end else begin
         seen_ff <= seen_in;
         neg_ff  <= neg_in;
         pos_ff  <= pos_in;
      end
      mag_ff <= mag_in;
   end

   assign status.neg       = neg_ff;
   assign status.emit      = (digit != 4'd0) | seen_ff | pos_zero;
   assign status.last      = pos_zero;
   assign status.char_code = CH_ZERO + {4'd0, digit};

endmodule

// ===== hw/rtl/sitda_ctrl.sv =====
// Controller: sequencing state machine and the registered result stage.
// Depends on sitda_pkg.

module sitda_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast,
   output sitda_pkg::sitda_cmd_type    cmd,
   input  sitda_pkg::sitda_status_type status
);
   import sitda_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SIGN  = 2'd1;
   localparam logic [1:0] ST_DIGIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       out_free;
   logic       emit;
   logic [7:0] emit_char;
   logic       emit_last;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // sequencing
   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      emit      = 1'b0;
      emit_char = status.char_code;
      emit_last = status.last;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (!status.neg) begin
               state_in = ST_DIGIT;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_char = CH_MINUS;
               emit_last = 1'b0;
               state_in  = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               cmd.step = 1'b1;
               emit     = status.emit;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result stage
   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = emit;
         char_in  = emit_char;
         last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== hw/rtl/sitda_checker.sv =====
// Port-level checks for signed_int_to_decimal_ascii, bound to the top level.
// Depends on sitda_pkg.

module sitda_checker #(
   parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [((VALUE_BITS+7)/8)*8-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [7:0]                      rsp_tdata,
   input logic                            rsp_tlast
);
   import sitda_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // only '-' or a digit is ever produced
   a_rsp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == CH_MINUS) ||
                     ((rsp_tdata >= CH_ZERO) && (rsp_tdata <= CH_ZERO + 8'd9)))
      else $error("rsp character out of range");

   // the sign never closes a number
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == CH_MINUS) |-> !rsp_tlast)
      else $error("minus sign flagged as last");

   // no new value is taken while a number is still being printed
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input accepted mid-number");

   // an offered value holds until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("req beat changed while waiting");

endmodule

bind signed_int_to_decimal_ascii sitda_checker #(
   .VALUE_BITS (VALUE_BITS)
) u_sitda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
// Self-checking bench for signed_int_to_decimal_ascii: drives signed values,
// predicts each decimal text character by character and checks every rsp beat.
// Depends on sitda_pkg and the RTL of the converter.

module signed_int_to_decimal_ascii_tb;
   import sitda_pkg::*;

   localparam int VBITS      = 32;
   localparam int DATA_BITS  = ((VBITS + 7) / 8) * 8;

   // one expected character beat
   typedef struct {
      logic [7:0] code;
      logic       last;
   } char_beat_type;

   // holds the decimal text still owed for every accepted value
   class text_scoreboard;
      char_beat_type owed_chars[$];
      int            mismatches;
      int            chars_checked;
      int            values_noted;
      int            negatives;

      function void note_mismatch(string what);
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $time, what);
         end
      endfunction

      // works out the decimal text of an accepted value
      function void note_value(logic [VBITS-1:0] value);
         logic [VBITS-1:0] magnitude;
         logic [7:0]       digits[$];
         char_beat_type    beat;
         values_noted++;
         magnitude = value[VBITS-1] ? (~value + 1'b1) : value;
         if (value[VBITS-1]) begin
            negatives++;
            beat.code = CH_MINUS;
            beat.last = 1'b0;
            owed_chars.push_back(beat);
         end
         // unsigned magnitude, so the most negative value is covered too
         do begin
            digits.push_front(CH_ZERO + 8'(magnitude % 10));
            magnitude = magnitude / 10;
         end while (magnitude != 0);
         foreach (digits[i]) begin
            beat.code = digits[i];
            beat.last = (i == digits.size() - 1);
            owed_chars.push_back(beat);
         end
      endfunction

      // compares one rsp beat with the oldest owed character
      function void check_char(logic [7:0] code, logic last);
         char_beat_type want;
         chars_checked++;
         if (owed_chars.size() == 0) begin
            note_mismatch($sformatf("unexpected char 0x%02h last=%b", code, last));
         end else begin
            want = owed_chars.pop_front();
            if (code !== want.code) begin
               note_mismatch($sformatf("char_code exp 0x%02h got 0x%02h", want.code, code));
            end
            if (last !== want.last) begin
               note_mismatch($sformatf("is_last exp %b got %b (char 0x%02h)",
                                       want.last, last, want.code));
            end
         end
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;  // [31:0] value
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;        // [7:0] char_code
   logic                 rsp_tlast;        // is_last

   text_scoreboard board;
   bit             quiet_tail;
   int             rsp_hold_request;

   signed_int_to_decimal_ascii #(.VALUE_BITS(VBITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // offer one value and hold it until the beat is taken
   task automatic send_value(input logic [VBITS-1:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      board.note_value(value);
   endtask

   // random gap between beats, none in the tail
   task automatic maybe_gap();
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.owed_chars.size() != 0) @(posedge clock);
   endtask

   // mixes full-range values with short, power-of-ten and boundary cases
   function automatic logic [VBITS-1:0] random_value();
      logic [VBITS-1:0] mag;
      logic [VBITS-1:0] pow;
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: mag = $urandom_range(0, 120);
         2: begin
            pow = 1;
            repeat ($urandom_range(0, 9)) pow = pow * 10;
            mag = pow + $urandom_range(0, 2) - 1;
         end
         3: mag = $urandom >> $urandom_range(1, 31);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h8000_0001;
               default: return 32'h0000_0000;
            endcase
         end
      endcase
      return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
   endfunction

   // stimulus
   initial begin : req_source
      logic [VBITS-1:0] corner_values[$];
      board = new;
      corner_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10,
                        32'd99, 32'd100, -32'sd100, 32'd7, -32'sd5, 32'd123456789,
                        -32'sd987654321, 32'd999999999, 32'd1000000000,
                        -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner values
      foreach (corner_values[i]) begin
         send_value(corner_values[i]);
         maybe_gap();
      end

      // random, both sides idling
      repeat (150) begin
         send_value(random_value());
         maybe_gap();
      end

      // receiver holds off while values keep coming, so the input backs up
      rsp_hold_request = 400;
      repeat (30) send_value(random_value());

      // sender waits for every character before going on
      wait_drained();

      repeat (180) begin
         send_value(random_value());
         maybe_gap();
      end

      // tail with no idling on either side
      quiet_tail = 1'b1;
      repeat (40) send_value(random_value());

      wait_drained();
      repeat (30) @(posedge clock);

      $display("Converted %0d values (%0d negative) into %0d characters, corners included",
               board.values_noted, board.negatives, board.chars_checked);
      $display("Mismatches: %0d, characters still owed: %0d",
               board.mismatches, board.owed_chars.size());
      if (board.mismatches == 0 && board.owed_chars.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // result side: checks each beat, stalls in bursts, honours a long hold-off
   initial begin : rsp_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_request > 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            board.check_char(rsp_tdata, rsp_tlast);
         end
      end
   end

   // watchdog
   initial begin : run_limit
      #3_000_000;
      $display("Run did not finish in time");
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_datapath.sv
hw/rtl/sitda_ctrl.sv
hw/rtl/signed_int_to_decimal_ascii.sv
hw/rtl/sitda_checker.sv
tb/signed_int_to_decimal_ascii_tb.sv
